>>> src/fck_pkg.sv
// Shared types, constants and the character classifier for the FASTA
// canonical k-mer extractor. No dependencies.
package fck_pkg;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_KMER      = 3'd0,
    ST_BAD_CHAR  = 3'd1,
    ST_MISPLACED = 3'd2,
    ST_NO_HEADER = 3'd3,
    ST_CONTIG_OV = 3'd4,
    ST_POS_OV    = 3'd5
  } status_t;

  // Character kinds: 0..3 are base codes A C G T.
  typedef logic [2:0] kind_t;
  localparam kind_t KIND_AMBIG = 3'd4;
  localparam kind_t KIND_OTHER = 3'd5;

  // Characters of interest.
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam logic [30:0] POS_MAX    = 31'h7FFF_FFFF;
  localparam logic [15:0] CONTIG_MAX = 16'hFFFF;

  localparam int KMER_OUT_W   = 46;
  localparam int BUCKET_OUT_W = 18;

  // One accepted input item.
  typedef struct packed {
    logic [7:0] text_byte;
    logic       genome_start;
  } item_t;

  // One result item.
  typedef struct packed {
    status_t                   status;
    logic [KMER_OUT_W-1:0]     canonical_kmer;
    logic signed [31:0]        signed_position;
    logic [15:0]               contig_id;
    logic [15:0]               genome_tag;
    logic [BUCKET_OUT_W-1:0]   bucket_index;
  } result_t;

  // Handshake between the core and the result register.
  typedef struct packed {
    logic can_load;
    logic load;
  } out_ctl_t;

  // Sort a byte into base code, ambiguity code or anything else.
  function automatic kind_t classify(input logic [7:0] c);
    logic [7:0] u;
    kind_t      k;
    u = (c >= 8'h61 && c <= 8'h7A) ? c - 8'd32 : c;
    case (u) inside
      8'h41: k = 3'd0;
      8'h43: k = 3'd1;
      8'h47: k = 3'd2;
      8'h54: k = 3'd3;
      8'h42, 8'h44, 8'h48, 8'h4B, 8'h4D, 8'h4E,
      8'h52, 8'h53, 8'h56, 8'h57, 8'h59: k = KIND_AMBIG;
      default: k = KIND_OTHER;
    endcase
    return k;
  endfunction

endpackage

>>> src/fck_if.sv
// Valid/ready channel interfaces for the text input and the k-mer results.
// Depends on fck_pkg for the output field widths.
interface fck_text_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       genome_start;

  modport source (output valid, text_byte, genome_start, input ready);
  modport sink (input valid, text_byte, genome_start, output ready);
endinterface

interface fck_kmer_if;
  logic                                valid;
  logic                                ready;
  logic [2:0]                          status;
  logic [fck_pkg::KMER_OUT_W-1:0]      canonical_kmer;
  logic signed [31:0]                  signed_position;
  logic [15:0]                         contig_id;
  logic [15:0]                         genome_tag;
  logic [fck_pkg::BUCKET_OUT_W-1:0]    bucket_index;

  modport source (output valid, status, canonical_kmer, signed_position, contig_id,
                  genome_tag, bucket_index, input ready);
  modport sink (input valid, status, canonical_kmer, signed_position, contig_id,
                genome_tag, bucket_index, output ready);
endinterface

>>> src/fck_in_stage.sv
// Input register for the text channel.
// Depends on fck_pkg and fck_text_if.
module fck_in_stage (
  input  logic            clk,
  input  logic            rst,
  fck_text_if.sink        text,
  input  logic            consume,
  output logic            item_valid,
  output fck_pkg::item_t  item
);

  logic valid;

  assign text.ready = !valid || consume;
  assign item_valid = valid;

  // Hold one item until the core takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (text.valid && text.ready) begin
      valid <= 1'b1;
    end else if (consume) begin
      valid <= 1'b0;
    end
    if (text.valid && text.ready) begin
      item.text_byte    <= text.text_byte;
      item.genome_start <= text.genome_start;
    end
  end

endmodule

>>> src/fck_core.sv
// Parse state, rolling k-mer registers and result formation.
// Depends on fck_pkg.
module fck_core #(
  parameter int KMER_BASES   = 23,
  parameter int BUCKET_BASES = 9
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               genome_id_we,
  input  logic [15:0]        genome_id_wdata,
  input  logic               item_valid,
  input  fck_pkg::item_t     item,
  input  logic               can_load,
  output logic               consume,
  output fck_pkg::out_ctl_t  ctl,
  output fck_pkg::result_t   res
);

  localparam int KW   = 2 * KMER_BASES;
  localparam int BW   = 2 * BUCKET_BASES;
  localparam int BGW  = $clog2(KMER_BASES + 1);
  localparam int RSH  = (KMER_BASES > BUCKET_BASES) ? 2 * (KMER_BASES - BUCKET_BASES) : 0;
  localparam int LSH  = (BUCKET_BASES > KMER_BASES) ? 2 * (BUCKET_BASES - KMER_BASES) : 0;
  localparam logic [BGW-1:0] BG_FULL = BGW'(KMER_BASES);

  logic [15:0]     genome_id;
  logic [KW-1:0]   forward_kmer, forward_kmer_next;
  logic [KW-1:0]   revcomp_kmer, revcomp_kmer_next;
  logic [BGW-1:0]  bases_gathered, bases_gathered_next;
  logic [30:0]     contig_position, contig_position_next;
  logic [15:0]     contig_counter, contig_counter_next;
  logic            in_header, in_header_next;
  logic            at_line_start, at_line_start_next;
  logic            first_header_seen, first_header_seen_next;
  logic            halted, halted_next;

  logic            fire;
  logic            has_result;
  logic            rev;
  logic [KW-1:0]   canon;
  logic [63:0]     canon_wide;
  logic [63:0]     bucket_wide;
  logic [23:0]     bucket_pad;

  assign fire    = item_valid && can_load;
  assign consume = fire;
  assign ctl.can_load = can_load;
  assign ctl.load     = fire && has_result;

  // Canonical pick and bucket from the updated k-mers.
  assign rev         = !(forward_kmer_next < revcomp_kmer_next);
  assign canon       = rev ? revcomp_kmer_next : forward_kmer_next;
  assign canon_wide  = 64'(canon);
  assign bucket_wide = (canon_wide >> RSH) << LSH;
  assign bucket_pad  = 24'(bucket_wide[BW-1:0]);

  // Next state and result for the item in the input register.
  always_comb begin
    fck_pkg::kind_t kind;
    logic [7:0]     c;
    logic           is_ws;
    c    = item.text_byte;
    kind = fck_pkg::classify(c);
    is_ws = (c == fck_pkg::CH_SPACE) || (c == fck_pkg::CH_TAB) || (c == fck_pkg::CH_LF) ||
            (c == fck_pkg::CH_VT) || (c == fck_pkg::CH_FF) || (c == fck_pkg::CH_CR);

    // Genome start clears the running state before the byte is parsed.
    if (item.genome_start) begin
      forward_kmer_next      = '0;
      revcomp_kmer_next      = '0;
      bases_gathered_next    = '0;
      contig_position_next   = '0;
      contig_counter_next    = '0;
      in_header_next         = 1'b0;
      at_line_start_next     = 1'b1;
      first_header_seen_next = 1'b0;
      halted_next            = 1'b0;
    end else begin
      forward_kmer_next      = forward_kmer;
      revcomp_kmer_next      = revcomp_kmer;
      bases_gathered_next    = bases_gathered;
      contig_position_next   = contig_position;
      contig_counter_next    = contig_counter;
      in_header_next         = in_header;
      at_line_start_next     = at_line_start;
      first_header_seen_next = first_header_seen;
      halted_next            = halted;
    end

    has_result = 1'b0;
    res.status = fck_pkg::ST_KMER;

    if (halted_next) begin
      has_result = 1'b0;
    end else if (!first_header_seen_next) begin
      if (c != fck_pkg::CH_GT) begin
        has_result = 1'b1;
        res.status = fck_pkg::ST_NO_HEADER;
      end else begin
        first_header_seen_next = 1'b1;
        in_header_next         = 1'b1;
        at_line_start_next     = 1'b0;
      end
    end else if (in_header_next) begin
      if (c == fck_pkg::CH_LF) begin
        in_header_next     = 1'b0;
        at_line_start_next = 1'b1;
      end
    end else if (is_ws) begin
      at_line_start_next = (c == fck_pkg::CH_LF);
    end else if (c == fck_pkg::CH_GT) begin
      if (!at_line_start_next) begin
        has_result = 1'b1;
        res.status = fck_pkg::ST_MISPLACED;
      end else if (contig_counter_next == fck_pkg::CONTIG_MAX) begin
        has_result = 1'b1;
        res.status = fck_pkg::ST_CONTIG_OV;
      end else begin
        contig_counter_next  = contig_counter_next + 16'd1;
        in_header_next       = 1'b1;
        at_line_start_next   = 1'b0;
        forward_kmer_next    = '0;
        revcomp_kmer_next    = '0;
        bases_gathered_next  = '0;
        contig_position_next = '0;
      end
    end else if (kind == fck_pkg::KIND_OTHER) begin
      has_result = 1'b1;
      res.status = fck_pkg::ST_BAD_CHAR;
    end else if (contig_position_next == fck_pkg::POS_MAX) begin
      has_result = 1'b1;
      res.status = fck_pkg::ST_POS_OV;
    end else begin
      at_line_start_next   = 1'b0;
      contig_position_next = contig_position_next + 31'd1;
      if (kind == fck_pkg::KIND_AMBIG) begin
        forward_kmer_next   = '0;
        revcomp_kmer_next   = '0;
        bases_gathered_next = '0;
      end else begin
        // Shift the base in: forward at the bottom, complement at the top.
        forward_kmer_next = {forward_kmer_next[KW-3:0], kind[1:0]};
        revcomp_kmer_next = {~kind[1:0], revcomp_kmer_next[KW-1:2]};
        if (bases_gathered_next != BG_FULL) begin
          bases_gathered_next = bases_gathered_next + BGW'(1);
        end
        has_result = (bases_gathered_next == BG_FULL);
      end
    end

    // Any error halts until the next genome start.
    if (has_result && res.status != fck_pkg::ST_KMER) begin
      halted_next = 1'b1;
    end

    res.contig_id  = contig_counter_next;
    res.genome_tag = genome_id;
    if (res.status == fck_pkg::ST_KMER) begin
      res.canonical_kmer  = canon_wide[fck_pkg::KMER_OUT_W-1:0];
      res.signed_position = rev ? -$signed({1'b0, contig_position_next})
                                : $signed({1'b0, contig_position_next});
      res.bucket_index    = bucket_pad[fck_pkg::BUCKET_OUT_W-1:0];
    end else begin
      res.canonical_kmer  = '0;
      res.signed_position = '0;
      res.bucket_index    = '0;
    end
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      genome_id <= '0;
    end else if (genome_id_we) begin
      genome_id <= genome_id_wdata;
    end
  end

  // Parse state advances once per item taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      forward_kmer      <= '0;
      revcomp_kmer      <= '0;
      bases_gathered    <= '0;
      contig_position   <= '0;
      contig_counter    <= '0;
      in_header         <= 1'b0;
      at_line_start     <= 1'b1;
      first_header_seen <= 1'b0;
      halted            <= 1'b0;
    end else if (fire) begin
      forward_kmer      <= forward_kmer_next;
      revcomp_kmer      <= revcomp_kmer_next;
      bases_gathered    <= bases_gathered_next;
      contig_position   <= contig_position_next;
      contig_counter    <= contig_counter_next;
      in_header         <= in_header_next;
      at_line_start     <= at_line_start_next;
      first_header_seen <= first_header_seen_next;
      halted            <= halted_next;
    end
  end

  // A halted block stays silent and frozen until a genome start.
  a_halted_silent: assert property (@(posedge clk) disable iff (rst)
    fire && halted && !item.genome_start |-> !has_result)
    else $error("result produced while halted");

  a_halted_frozen: assert property (@(posedge clk) disable iff (rst)
    fire && halted && !item.genome_start |=> $stable(contig_position) && $stable(forward_kmer))
    else $error("state moved while halted");

  // Every error result leaves the block halted.
  a_error_halts: assert property (@(posedge clk) disable iff (rst)
    fire && has_result && res.status != fck_pkg::ST_KMER |=> halted)
    else $error("error did not halt the block");

  // A k-mer result needs a full window and a nonzero position.
  a_kmer_full: assert property (@(posedge clk) disable iff (rst)
    fire && has_result && res.status == fck_pkg::ST_KMER |=>
      bases_gathered == BG_FULL && contig_position != '0)
    else $error("k-mer emitted before the window filled");

endmodule

>>> src/fck_out_stage.sv
// Result register driving the k-mer output channel.
// Depends on fck_pkg and fck_kmer_if.
module fck_out_stage (
  input  logic               clk,
  input  logic               rst,
  input  fck_pkg::out_ctl_t  ctl,
  input  fck_pkg::result_t   res,
  output logic               can_load,
  fck_kmer_if.source         kmers
);

  logic             valid;
  fck_pkg::result_t data;

  assign can_load = !valid || kmers.ready;

  // Refill whenever the held item is gone or is being taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.can_load) begin
      valid <= ctl.load;
    end
    if (ctl.load) begin
      data <= res;
    end
  end

  assign kmers.valid           = valid;
  assign kmers.status          = data.status;
  assign kmers.canonical_kmer  = data.canonical_kmer;
  assign kmers.signed_position = data.signed_position;
  assign kmers.contig_id       = data.contig_id;
  assign kmers.genome_tag      = data.genome_tag;
  assign kmers.bucket_index    = data.bucket_index;

endmodule

>>> src/fasta_canonical_kmer_extractor.sv
// Top level of the FASTA canonical k-mer extractor.
// Depends on fck_pkg, fck_if, fck_in_stage, fck_core and fck_out_stage.
//
//   Channel    Dir  Handshake              Payload
//   text       in   valid/ready            text_byte, genome_start
//   kmers      out  valid/ready            status, canonical_kmer, signed_position,
//                                          contig_id, genome_tag, bucket_index
//   genome_id  in   genome_id_we (write)   genome_id_wdata
//
// One byte is taken every cycle while the result register can load; its result, if any,
// reaches the kmers channel through the input register and then the result register.
// The parse step between the two registers sets that rate: one byte per pass.
// Reset is synchronous and clears the parse state and genome_id; no clearing pass.
// When the result register is full and not taken, the input register holds and
// the text channel drops ready; one item stays buffered at each side.
module fasta_canonical_kmer_extractor #(
  parameter int KMER_BASES   = 23,
  parameter int BUCKET_BASES = 9
) (
  input  logic        clk,
  input  logic        rst,
  fck_text_if.sink    text,
  fck_kmer_if.source  kmers,
  input  logic        genome_id_we,
  input  logic [15:0] genome_id_wdata
);

  logic              item_valid;
  logic              consume;
  logic              can_load;
  fck_pkg::item_t    item;
  fck_pkg::out_ctl_t ctl;
  fck_pkg::result_t  res;

  fck_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .text       (text),
    .consume    (consume),
    .item_valid (item_valid),
    .item       (item)
  );

  fck_core #(
    .KMER_BASES   (KMER_BASES),
    .BUCKET_BASES (BUCKET_BASES)
  ) u_core (
    .clk             (clk),
    .rst             (rst),
    .genome_id_we    (genome_id_we),
    .genome_id_wdata (genome_id_wdata),
    .item_valid      (item_valid),
    .item            (item),
    .can_load        (can_load),
    .consume         (consume),
    .ctl             (ctl),
    .res             (res)
  );

  fck_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .res      (res),
    .can_load (can_load),
    .kmers    (kmers)
  );

endmodule

>>> tb/sv/fasta_canonical_kmer_extractor_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for fasta_canonical_kmer_extractor: streams FASTA text
// into the text channel, predicts every k-mer and error result, and checks the kmers channel.
// Depends on fck_pkg, fck_if and the extractor RTL.
module fasta_canonical_kmer_extractor_tb;

  localparam int KMER_LEN     = 23;
  localparam int KMER_W       = 2 * KMER_LEN;
  localparam int BUCKET_LEN   = 9;
  localparam int BUCKET_SHIFT = 2 * (KMER_LEN - BUCKET_LEN);
  localparam int LONG_STALL   = 300;
  localparam int DRAIN_CYCLES = 8;

  // Base codes as the extractor packs them.
  localparam fck_pkg::kind_t KIND_A = 3'd0;
  localparam fck_pkg::kind_t KIND_C = 3'd1;
  localparam fck_pkg::kind_t KIND_G = 3'd2;
  localparam fck_pkg::kind_t KIND_T = 3'd3;

  // Character pools for the text generator.
  localparam logic [31:0] BASE_CHARS  = "ACGT";
  localparam logic [87:0] AMBIG_CHARS = "BDHKMNRSVWY";
  localparam logic [39:0] WS_CHARS    = {fck_pkg::CH_SPACE, fck_pkg::CH_TAB, fck_pkg::CH_VT,
                                         fck_pkg::CH_FF, fck_pkg::CH_CR};

  logic        clk;
  logic        rst;
  logic        genome_id_we;
  logic [15:0] genome_id_wdata;

  fck_text_if text_ch ();
  fck_kmer_if kmer_ch ();

  fasta_canonical_kmer_extractor #(
    .KMER_BASES   (KMER_LEN),
    .BUCKET_BASES (BUCKET_LEN)
  ) u_dut (
    .clk             (clk),
    .rst             (rst),
    .text            (text_ch),
    .kmers           (kmer_ch),
    .genome_id_we    (genome_id_we),
    .genome_id_wdata (genome_id_wdata)
  );

  // Text waiting to be sent and results waiting to arrive.
  fck_pkg::item_t   text_queue[$];
  fck_pkg::result_t expected_results[$];

  int               send_idle_pct = 0;
  int               recv_idle_pct = 0;
  int               error_count   = 0;
  int               stalls_asked  = 0;
  int               stalls_done   = 0;
  int               stall_left    = 0;
  bit               byte_taken    = 1'b0;
  fck_pkg::item_t   next_item;
  fck_pkg::result_t predicted;
  fck_pkg::result_t want;

  // Parser state mirrored by the predictor.
  logic [KMER_W-1:0] fwd_code;
  logic [KMER_W-1:0] rc_code;
  logic [4:0]        filled_bases;
  logic [30:0]       base_pos;
  logic [15:0]       contig_num;
  logic [15:0]       genome_reg;
  bit                in_title;
  bit                line_start;
  bit                title_seen;
  bit                stopped;

  function automatic void clear_parse_state();
    fwd_code     = '0;
    rc_code      = '0;
    filled_bases = '0;
    base_pos     = '0;
    contig_num   = '0;
    in_title     = 1'b0;
    line_start   = 1'b1;
    title_seen   = 1'b0;
    stopped      = 1'b0;
  endfunction

  // An error result carries only the status and the two ids, and halts the parser.
  function automatic fck_pkg::result_t error_result(input fck_pkg::status_t code);
    fck_pkg::result_t r;
    r            = '0;
    r.status     = code;
    r.contig_id  = contig_num;
    r.genome_tag = genome_reg;
    stopped      = 1'b1;
    return r;
  endfunction

  // Advance the parser by one byte; returns 1 when the byte yields a result.
  function automatic bit parse_byte(input logic [7:0] c, input logic gs,
                                    output fck_pkg::result_t r);
    logic [7:0]        u;
    fck_pkg::kind_t    kind;
    bit                flip;
    logic [KMER_W-1:0] canon;
    r = '0;
    if (gs) clear_parse_state();
    if (stopped) return 1'b0;

    // Anything but '>' before the first header is an error, whitespace included.
    if (!title_seen) begin
      if (c != fck_pkg::CH_GT) begin
        r = error_result(fck_pkg::ST_NO_HEADER);
        return 1'b1;
      end
      title_seen = 1'b1;
      in_title   = 1'b1;
      line_start = 1'b0;
      return 1'b0;
    end

    // Header text is skipped up to its newline.
    if (in_title) begin
      if (c == fck_pkg::CH_LF) begin
        in_title   = 1'b0;
        line_start = 1'b1;
      end
      return 1'b0;
    end

    case (c)
      fck_pkg::CH_SPACE, fck_pkg::CH_TAB, fck_pkg::CH_LF, fck_pkg::CH_VT, fck_pkg::CH_FF,
      fck_pkg::CH_CR: begin
        line_start = (c == fck_pkg::CH_LF);
        return 1'b0;
      end
      default: ;
    endcase

    // A later header at a line start opens the next contig, unless the counter is full.
    if (c == fck_pkg::CH_GT) begin
      if (!line_start) begin
        r = error_result(fck_pkg::ST_MISPLACED);
        return 1'b1;
      end
      if (contig_num == fck_pkg::CONTIG_MAX) begin
        r = error_result(fck_pkg::ST_CONTIG_OV);
        return 1'b1;
      end
      contig_num++;
      in_title     = 1'b1;
      line_start   = 1'b0;
      fwd_code     = '0;
      rc_code      = '0;
      filled_bases = '0;
      base_pos     = '0;
      return 1'b0;
    end

    u = (c >= 8'h61 && c <= 8'h7A) ? c - 8'd32 : c;
    case (u)
      "A":     kind = KIND_A;
      "C":     kind = KIND_C;
      "G":     kind = KIND_G;
      "T":     kind = KIND_T;
      "B", "D", "H", "K", "M", "N", "R", "S", "V", "W", "Y": kind = fck_pkg::KIND_AMBIG;
      default: kind = fck_pkg::KIND_OTHER;
    endcase
    if (kind == fck_pkg::KIND_OTHER) begin
      r = error_result(fck_pkg::ST_BAD_CHAR);
      return 1'b1;
    end
    if (base_pos == fck_pkg::POS_MAX) begin
      r = error_result(fck_pkg::ST_POS_OV);
      return 1'b1;
    end
    line_start = 1'b0;
    base_pos++;

    // Ambiguity codes take a position but start the k-mer over.
    if (kind == fck_pkg::KIND_AMBIG) begin
      fwd_code     = '0;
      rc_code      = '0;
      filled_bases = '0;
      return 1'b0;
    end

    fwd_code = {fwd_code[KMER_W-3:0], kind[1:0]};
    rc_code  = {~kind[1:0], rc_code[KMER_W-1:2]};
    if (filled_bases < KMER_LEN) filled_bases++;
    if (filled_bases < KMER_LEN) return 1'b0;

    // On a tie the reverse complement wins.
    flip  = !(fwd_code < rc_code);
    canon = flip ? rc_code : fwd_code;
    r.status          = fck_pkg::ST_KMER;
    r.canonical_kmer  = canon;
    r.signed_position = flip ? -$signed({1'b0, base_pos}) : $signed({1'b0, base_pos});
    r.contig_id       = contig_num;
    r.genome_tag      = genome_reg;
    r.bucket_index    = canon[BUCKET_SHIFT +: fck_pkg::BUCKET_OUT_W];
    return 1'b1;
  endfunction

  task automatic compare_field(input string what, input logic [63:0] exp_val,
                               input logic [63:0] got_val);
    if (exp_val !== got_val) begin
      error_count++;
      $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
               $time, what, exp_val, got_val);
    end
  endtask

  task automatic push_item(input logic [7:0] b, input logic gs);
    fck_pkg::item_t it;
    it.text_byte    = b;
    it.genome_start = gs;
    text_queue.push_back(it);
  endtask

  // A '>' line with a few random bytes of title text.
  task automatic push_header(input logic gs);
    logic [7:0] b;
    push_item(fck_pkg::CH_GT, gs);
    repeat ($urandom_range(6)) begin
      b = 8'($urandom_range(255));
      if (b == fck_pkg::CH_LF) b = fck_pkg::CH_GT;
      push_item(b, 1'b0);
    end
    push_item(fck_pkg::CH_LF, 1'b0);
  endtask

  // Sequence lines of mixed-case bases with some ambiguity codes and whitespace.
  // Unless clean is set, a rare stray byte or '>' breaks the record.
  task automatic push_sequence(input int len, input bit clean);
    int         col;
    int         width;
    int         pick;
    bit         run;
    logic [7:0] b;
    logic [7:0] run_ch;
    logic [7:0] lc;
    run    = ($urandom_range(9) == 0);
    run_ch = BASE_CHARS[8*$urandom_range(3) +: 8];
    width  = $urandom_range(8, 60);
    col    = 0;
    for (int i = 0; i < len; i++) begin
      pick = clean ? $urandom_range(919) : $urandom_range(999);
      lc   = ($urandom_range(1) != 0) ? 8'h20 : 8'h00;
      if (run)
        b = run_ch | lc;
      else if (pick < 850)
        b = BASE_CHARS[8*$urandom_range(3) +: 8] | lc;
      else if (pick < 920)
        b = AMBIG_CHARS[8*$urandom_range(10) +: 8] | lc;
      else if (pick < 995)
        b = WS_CHARS[8*$urandom_range(4) +: 8];
      else if (pick < 998)
        b = 8'($urandom_range(255));
      else
        b = fck_pkg::CH_GT;
      push_item(b, 1'b0);
      col++;
      if (col >= width) begin
        push_item(fck_pkg::CH_LF, 1'b0);
        col = 0;
      end
    end
    push_item(fck_pkg::CH_LF, 1'b0);
  endtask

  // One genome: mostly well-formed records, sometimes stray text with no header.
  task automatic push_genome();
    int len;
    if ($urandom_range(99) < 5) begin
      push_item(8'($urandom_range(255)), 1'b1);
      repeat ($urandom_range(3)) push_item(8'($urandom_range(255)), 1'b0);
    end else begin
      for (int k = 0; k < $urandom_range(1, 3); k++) begin
        push_header(k == 0);
        len = ($urandom_range(19) == 0) ? 150 : $urandom_range(70);
        push_sequence(len, 1'b0);
      end
    end
  endtask

  task automatic push_genomes(input int count);
    int start;
    start = text_queue.size();
    while (text_queue.size() - start < count) push_genome();
  endtask

  // Register writes happen only while nothing is in flight.
  task automatic write_genome_id(input logic [15:0] value);
    @(negedge clk);
    genome_id_we    <= 1'b1;
    genome_id_wdata <= value;
    @(negedge clk);
    genome_id_we    <= 1'b0;
    genome_reg = value;
  endtask

  task automatic wait_until_drained();
    while (text_queue.size() != 0 || text_ch.valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Text driver: offers the next queued item once the previous one is taken.
  always @(negedge clk) begin
    if (rst) begin
      text_ch.valid <= 1'b0;
    end else if (!text_ch.valid || byte_taken) begin
      if (text_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next_item = text_queue.pop_front();
        text_ch.valid        <= 1'b1;
        text_ch.text_byte    <= next_item.text_byte;
        text_ch.genome_start <= next_item.genome_start;
      end else begin
        text_ch.valid <= 1'b0;
      end
    end
  end

  // Result sink: random back-pressure plus an occasional long hold-off.
  always @(negedge clk) begin
    if (rst) begin
      kmer_ch.ready <= 1'b0;
    end else if (stalls_done != stalls_asked) begin
      stalls_done   <= stalls_asked;
      stall_left    <= LONG_STALL;
      kmer_ch.ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left    <= stall_left - 1;
      kmer_ch.ready <= 1'b0;
    end else begin
      kmer_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Monitor: check each delivered result, then predict from each accepted byte.
  always @(posedge clk) begin
    if (rst) begin
      byte_taken = 1'b0;
    end else begin
      if (kmer_ch.valid && kmer_ch.ready) begin
        if (expected_results.size() == 0) begin
          error_count++;
          $display("%0t ns: result with none expected, status %0d, kmer 0x%0h",
                   $time, kmer_ch.status, kmer_ch.canonical_kmer);
        end else begin
          want = expected_results.pop_front();
          compare_field("status", 64'(want.status), 64'(kmer_ch.status));
          compare_field("canonical_kmer", 64'(want.canonical_kmer),
                        64'(kmer_ch.canonical_kmer));
          compare_field("signed_position", {32'd0, want.signed_position},
                        {32'd0, kmer_ch.signed_position});
          compare_field("contig_id", 64'(want.contig_id), 64'(kmer_ch.contig_id));
          compare_field("genome_tag", 64'(want.genome_tag), 64'(kmer_ch.genome_tag));
          compare_field("bucket_index", 64'(want.bucket_index), 64'(kmer_ch.bucket_index));
        end
      end
      byte_taken = text_ch.valid && text_ch.ready;
      if (byte_taken && parse_byte(text_ch.text_byte, text_ch.genome_start, predicted))
        expected_results.push_back(predicted);
    end
  end

  // Stimulus sequence.
  initial begin
    rst                  = 1'b1;
    text_ch.valid        = 1'b0;
    text_ch.text_byte    = 8'h00;
    text_ch.genome_start = 1'b0;
    kmer_ch.ready        = 1'b0;
    genome_id_we         = 1'b0;
    genome_id_wdata      = 16'h0000;
    genome_reg           = 16'h0000;
    clear_parse_state();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: errors before a header, header handling, misplaced '>' and bad bytes.
    write_genome_id(16'hFFFF);
    push_item("A", 1'b1);
    push_item("C", 1'b0);
    push_item(fck_pkg::CH_SPACE, 1'b1);
    push_item(8'h00, 1'b1);
    push_item(fck_pkg::CH_GT, 1'b1);
    push_item(fck_pkg::CH_GT, 1'b0);
    push_item(8'hFF, 1'b0);
    push_item(fck_pkg::CH_LF, 1'b0);
    push_item("n", 1'b0);
    push_item("g", 1'b0);
    push_item(fck_pkg::CH_GT, 1'b0);
    push_item(fck_pkg::CH_GT, 1'b1);
    push_item(fck_pkg::CH_LF, 1'b0);
    push_item(fck_pkg::CH_TAB, 1'b0);
    push_item(fck_pkg::CH_LF, 1'b0);
    push_item("@", 1'b0);
    push_item(fck_pkg::CH_GT, 1'b1);
    push_item(fck_pkg::CH_LF, 1'b0);
    push_item(fck_pkg::CH_CR, 1'b0);
    push_item(fck_pkg::CH_VT, 1'b0);
    push_item(fck_pkg::CH_FF, 1'b0);
    push_item(8'h80, 1'b0);
    push_item(fck_pkg::CH_GT, 1'b1);
    push_item(fck_pkg::CH_LF, 1'b0);
    push_item("Z", 1'b0);
    wait_until_drained();

    // Random records, eager sender against a busy receiver.
    write_genome_id(16'h0000);
    send_idle_pct = 24;
    recv_idle_pct = 86;
    push_genomes(260);
    wait_until_drained();

    // The other way round.
    write_genome_id(16'($urandom));
    send_idle_pct = 86;
    recv_idle_pct = 24;
    push_genomes(260);
    wait_until_drained();

    // Full rate, with one long receiver hold-off so the input side backs up.
    write_genome_id(16'($urandom));
    send_idle_pct = 0;
    recv_idle_pct = 0;
    push_genomes(260);
    @(negedge clk);
    stalls_asked++;
    wait_until_drained();

    if (error_count == 0 && expected_results.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #20_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
